/* src/sao_pkg.sv */
// Shared constants, types and arithmetic helpers for the straight-alpha overlay blend.
// Used by every module of the block; it depends on nothing else.
package sao_pkg;

    localparam int QUOT_W    = 8;
    localparam int NUM_W     = 24;
    localparam int DEN_W     = 16;
    localparam int PROD_W    = 16;
    localparam int NUM_LANES = 4;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_LAT   = QUOT_W;
    localparam int LANE_LAT  = DIV_LAT + 2;
    localparam int MERGE_LAT = DIV_LAT + 2;
    localparam int MIX_LAT   = 2;
    localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT + MIX_LAT;

    localparam logic [7:0]       ALPHA_OPAQUE   = 8'd255;
    localparam logic [7:0]       ALPHA_CLEAR    = 8'd0;
    localparam logic [7:0]       ROUND_BIAS     = 8'd128;
    localparam logic [NUM_W-1:0] UNPREMUL_SCALE = 24'd65025;

    typedef enum logic [1:0] {
        MODE_PACKED,
        MODE_ALPHA,
        MODE_LUMA,
        MODE_CHROMA
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAIN_HAS_ALPHA,
        REG_CHROMA_HSUB,
        REG_CHROMA_VSUB
    } reg_idx_t;

    typedef struct packed {
        logic main_has_alpha;
        logic chroma_hsub;
        logic chroma_vsub;
    } cfg_t;

    typedef struct packed {
        logic [7:0] oa;
        logic [7:0] ma;
        logic [7:0] sa;
        logic [7:0] mc;
    } lane_out_t;

    // Divide by 255 with rounding: ((x + 128) * 257) >> 16.
    function automatic logic [7:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0]   biased;
        logic [PROD_W+8:0] scaled;
        biased = {1'b0, x} + {{(PROD_W-7){1'b0}}, ROUND_BIAS};
        scaled = {biased, 8'h00} + {8'h00, biased};
        return scaled[PROD_W+7:PROD_W];
    endfunction

    function automatic logic [NUM_W-1:0] unpremul_num(input logic [7:0] a);
        return UNPREMUL_SCALE * {{(NUM_W-8){1'b0}}, a};
    endfunction

    // 255*(a+m) - a*m, written as 255*a + m*(255-a).
    function automatic logic [DEN_W-1:0] unpremul_den(input logic [7:0] a,
                                                      input logic [7:0] m);
        logic [7:0]       inv;
        logic [DEN_W-1:0] a255;
        logic [DEN_W-1:0] mprod;
        inv   = ALPHA_OPAQUE - a;
        a255  = {a, 8'h00} - {8'h00, a};
        mprod = {8'h00, m} * {8'h00, inv};
        return a255 + mprod;
    endfunction

    function automatic logic needs_div(input logic has_alpha, input logic [7:0] a);
        return has_alpha && (a != ALPHA_CLEAR) && (a != ALPHA_OPAQUE);
    endfunction

endpackage

/* src/sao_div_pipe.sv */
// Pipelined restoring divider with an 8-bit quotient, one quotient bit per stage.
// Depends on sao_pkg for widths; the dividend must be below 256 times the divisor.
module sao_div_pipe (
    input  logic                        clk,
    input  logic [sao_pkg::NUM_W-1:0]   num,
    input  logic [sao_pkg::DEN_W-1:0]   den,
    output logic [sao_pkg::QUOT_W-1:0]  quo
);

    logic [sao_pkg::NUM_W-1:0]  rem_reg [sao_pkg::QUOT_W-1];
    logic [sao_pkg::DEN_W-1:0]  den_reg [sao_pkg::QUOT_W-1];
    logic [sao_pkg::QUOT_W-1:0] quo_reg [sao_pkg::QUOT_W];

    genvar k;
    for (k = 0; k < sao_pkg::QUOT_W; k++)
    begin : g_stage
        localparam int BIT_POS = sao_pkg::QUOT_W - 1 - k;

        logic [sao_pkg::NUM_W-1:0]  rem_in;
        logic [sao_pkg::DEN_W-1:0]  den_in;
        logic [sao_pkg::QUOT_W-1:0] quo_in;
        logic [sao_pkg::NUM_W:0]    trial;
        logic [sao_pkg::NUM_W:0]    diff;
        logic                       fits;
        logic [sao_pkg::QUOT_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_follow
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            trial = {{(sao_pkg::NUM_W + 1 - sao_pkg::DEN_W){1'b0}}, den_in} << BIT_POS;
            fits  = {1'b0, rem_in} >= trial;
            diff  = {1'b0, rem_in} - trial;
            quo_next = quo_in;
            quo_next[BIT_POS] = fits;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next;
        end

        if (k < sao_pkg::QUOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fits ? diff[sao_pkg::NUM_W-1:0] : rem_in;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[sao_pkg::QUOT_W-1];

endmodule

/* src/sao_alpha_lane.sv */
// One alpha lane: un-premultiplies an overlay alpha byte against its main alpha byte
// and composites the main alpha. Depends on sao_pkg and sao_div_pipe.
module sao_alpha_lane (
    input  logic               clk,
    input  sao_pkg::cfg_t      cfg,
    input  logic [7:0]         oa,
    input  logic [7:0]         ma,
    output sao_pkg::lane_out_t lane_out
);

    typedef struct packed {
        logic                       byp;
        logic [7:0]                 oa;
        logic [7:0]                 ma;
        logic [sao_pkg::PROD_W-1:0] prod;
    } lane_side_t;

    logic [sao_pkg::NUM_W-1:0]  num_reg;
    logic [sao_pkg::DEN_W-1:0]  den_reg;
    lane_side_t                 front_reg;
    lane_side_t                 front_next;
    lane_side_t                 dly_reg [sao_pkg::DIV_LAT];
    logic [sao_pkg::QUOT_W-1:0] quo;
    sao_pkg::lane_out_t         out_reg;
    sao_pkg::lane_out_t         out_next;
    lane_side_t                 last;

    always_comb
    begin
        front_next.byp  = !sao_pkg::needs_div(cfg.main_has_alpha, oa);
        front_next.oa   = oa;
        front_next.ma   = ma;
        front_next.prod = {8'h00, sao_pkg::ALPHA_OPAQUE - ma} * {8'h00, oa};
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= sao_pkg::unpremul_num(oa);
        den_reg   <= sao_pkg::unpremul_den(oa, ma);
        front_reg <= front_next;
        dly_reg[0] <= front_reg;
        for (int i = 1; i < sao_pkg::DIV_LAT; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
        out_reg <= out_next;
    end

    sao_div_pipe u_div (
        .clk (clk),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    assign last = dly_reg[sao_pkg::DIV_LAT-1];

    always_comb
    begin
        out_next.oa = last.oa;
        out_next.ma = last.ma;
        out_next.sa = last.byp ? last.oa : quo;
        if (!cfg.main_has_alpha || out_next.sa == sao_pkg::ALPHA_CLEAR)
        begin
            out_next.mc = last.ma;
        end
        else if (out_next.sa == sao_pkg::ALPHA_OPAQUE)
        begin
            out_next.mc = last.oa;
        end
        else
        begin
            out_next.mc = last.ma + sao_pkg::div255(last.prod);
        end
    end

    assign lane_out = out_reg;

endmodule

/* src/sao_merge.sv */
// Merging stage: picks or averages the lane alphas by mode and runs the second
// un-premultiply against the composited main alpha. Depends on sao_pkg and sao_div_pipe.
module sao_merge (
    input  logic                                         clk,
    input  sao_pkg::cfg_t                                cfg,
    input  sao_pkg::mode_t                               mode,
    input  logic                                         right_valid,
    input  logic                                         below_valid,
    input  sao_pkg::lane_out_t [sao_pkg::NUM_LANES-1:0]  lanes,
    output logic [7:0]                                   alpha
);

    function automatic logic [7:0] avg4(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic hs, input logic vs,
                                        input logic rv, input logic bv);
        logic [9:0] sum4;
        logic [8:0] sum_h;
        logic [8:0] sum_v;
        logic [7:0] h;
        logic [7:0] v;
        logic [8:0] hv;
        sum4  = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
        sum_h = {1'b0, b0} + {1'b0, b1};
        sum_v = {1'b0, b0} + {1'b0, b2};
        h     = (hs && rv) ? sum_h[8:1] : b0;
        v     = (vs && bv) ? sum_v[8:1] : b0;
        hv    = {1'b0, h} + {1'b0, v};
        if (hs && vs && rv && bv)
        begin
            return sum4[9:2];
        end
        else if (hs || vs)
        begin
            return hv[8:1];
        end
        return b0;
    endfunction

    logic [7:0]                 a_in;
    logic [7:0]                 m_in;
    logic                       byp;
    logic [sao_pkg::NUM_W-1:0]  num_reg;
    logic [sao_pkg::DEN_W-1:0]  den_reg;
    logic                       byp_reg;
    logic [7:0]                 aval_reg;
    logic                       byp_dly_reg [sao_pkg::DIV_LAT];
    logic [7:0]                 aval_dly_reg [sao_pkg::DIV_LAT];
    logic [sao_pkg::QUOT_W-1:0] quo;
    logic [7:0]                 alpha_reg;
    logic [7:0]                 alpha_next;

    always_comb
    begin
        a_in = lanes[0].sa;
        m_in = lanes[0].ma;
        byp  = 1'b1;
        case (mode)
            sao_pkg::MODE_PACKED, sao_pkg::MODE_ALPHA:
            begin
                a_in = lanes[0].sa;
                byp  = 1'b1;
            end
            sao_pkg::MODE_LUMA:
            begin
                a_in = lanes[0].oa;
                m_in = lanes[0].mc;
                byp  = !sao_pkg::needs_div(cfg.main_has_alpha, a_in);
            end
            sao_pkg::MODE_CHROMA:
            begin
                a_in = avg4(lanes[0].oa, lanes[1].oa, lanes[2].oa, lanes[3].oa,
                            cfg.chroma_hsub, cfg.chroma_vsub, right_valid, below_valid);
                m_in = avg4(lanes[0].mc, lanes[1].mc, lanes[2].mc, lanes[3].mc,
                            cfg.chroma_hsub, cfg.chroma_vsub, right_valid, below_valid);
                byp  = !sao_pkg::needs_div(cfg.main_has_alpha, a_in);
            end
            default:
            begin
                byp = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= sao_pkg::unpremul_num(a_in);
        den_reg  <= sao_pkg::unpremul_den(a_in, m_in);
        byp_reg  <= byp;
        aval_reg <= a_in;
        byp_dly_reg[0]  <= byp_reg;
        aval_dly_reg[0] <= aval_reg;
        for (int i = 1; i < sao_pkg::DIV_LAT; i++)
        begin
            byp_dly_reg[i]  <= byp_dly_reg[i-1];
            aval_dly_reg[i] <= aval_dly_reg[i-1];
        end
        alpha_reg <= alpha_next;
    end

    sao_div_pipe u_div (
        .clk (clk),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    assign alpha_next = byp_dly_reg[sao_pkg::DIV_LAT-1] ? aval_dly_reg[sao_pkg::DIV_LAT-1]
                                                        : quo;
    assign alpha = alpha_reg;

endmodule

/* src/sao_mix_lane.sv */
// One colour lane: mixes a main and an overlay sample by a straight alpha, with
// rounding division by 255, in two register stages. Depends on sao_pkg.
module sao_mix_lane (
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] alpha,
    input  logic [7:0] main_val,
    input  logic [7:0] over_val,
    output logic [7:0] blend
);

    logic signed [9:0]          diff;
    logic signed [8:0]          a_s;
    logic signed [18:0]         prod;
    logic signed [18:0]         base;
    logic signed [18:0]         sum;
    logic [sao_pkg::PROD_W-1:0] sum_reg;
    logic                       keep_main_reg;
    logic                       take_over_reg;
    logic [7:0]                 main_reg;
    logic [7:0]                 over_reg;
    logic [7:0]                 blend_reg;
    logic [7:0]                 blend_next;

    // m*(255-a) + o*a is folded into 255*m + a*(o-m).
    always_comb
    begin
        diff = $signed({2'b00, over_val}) - $signed({2'b00, main_val});
        a_s  = $signed({1'b0, alpha});
        prod = diff * a_s;
        base = $signed({3'b000, main_val, 8'h00}) - $signed({11'd0, main_val});
        sum  = base + prod;
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum[sao_pkg::PROD_W-1:0];
        keep_main_reg <= !en || (alpha == sao_pkg::ALPHA_CLEAR);
        take_over_reg <= alpha == sao_pkg::ALPHA_OPAQUE;
        main_reg      <= main_val;
        over_reg      <= over_val;
        blend_reg     <= blend_next;
    end

    always_comb
    begin
        if (keep_main_reg)
        begin
            blend_next = main_reg;
        end
        else if (take_over_reg)
        begin
            blend_next = over_reg;
        end
        else
        begin
            blend_next = sao_pkg::div255(sum_reg);
        end
    end

    assign blend = blend_reg;

endmodule

/* src/straight_alpha_overlay_blend.sv */
// Top level of the straight-alpha overlay blend: configuration registers, four alpha
// lanes, the merging stage, three colour lanes and the item delay line.
// Depends on sao_pkg, sao_alpha_lane, sao_merge and sao_mix_lane.
//
//  Channel   Signals                                        Transfer
//  input     start, busy, mode .. below_valid               start high, busy low
//  result    done, out_red_or_sample .. out_alpha           done high, one cycle
//  config    cfg_write, cfg_index, cfg_data                 cfg_write high
//
// One item is accepted every clock; busy is always low.
// Each result passes through an 8-stage divider in each alpha lane and another in the
// merging stage, a front and an output register around each, and two stages in the
// colour lanes.
// Reset clears the configuration registers and the valid bits of the delay line.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module straight_alpha_overlay_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    over_red_or_sample,
    input  logic [7:0]                    over_green,
    input  logic [7:0]                    over_blue,
    input  logic [31:0]                   over_alpha_quad,
    input  logic [7:0]                    main_red_or_sample,
    input  logic [7:0]                    main_green,
    input  logic [7:0]                    main_blue,
    input  logic [31:0]                   main_alpha_quad,
    input  logic                          right_valid,
    input  logic                          below_valid,
    output logic                          done,
    output logic [7:0]                    out_red_or_sample,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic [7:0]                    out_alpha,
    input  logic                          cfg_write,
    input  logic [sao_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);

    typedef struct packed {
        sao_pkg::mode_t mode;
        logic           rv;
        logic           bv;
        logic [7:0]     o_r;
        logic [7:0]     o_g;
        logic [7:0]     o_b;
        logic [7:0]     m_r;
        logic [7:0]     m_g;
        logic [7:0]     m_b;
        logic [7:0]     alpha;
    } side_t;

    localparam int MERGE_TAP = sao_pkg::LANE_LAT - 1;
    localparam int MIX_TAP   = sao_pkg::LANE_LAT + sao_pkg::MERGE_LAT - 1;

    sao_pkg::cfg_t                               cfg_reg;
    sao_pkg::cfg_t                               cfg_next;
    logic                                        accept;
    logic [sao_pkg::PIPE_LAT-1:0]                valid_reg;
    logic [sao_pkg::PIPE_LAT-1:0]                valid_next;
    side_t                                       side_reg [sao_pkg::PIPE_LAT];
    side_t                                       side_next [sao_pkg::PIPE_LAT];
    sao_pkg::lane_out_t [sao_pkg::NUM_LANES-1:0] lanes;
    logic [7:0]                                  alpha_sel;
    logic [7:0]                                  merge_alpha;
    side_t                                       mix_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (sao_pkg::reg_idx_t'(cfg_index))
                sao_pkg::REG_MAIN_HAS_ALPHA: cfg_next.main_has_alpha = cfg_data;
                sao_pkg::REG_CHROMA_HSUB:    cfg_next.chroma_hsub    = cfg_data;
                sao_pkg::REG_CHROMA_VSUB:    cfg_next.chroma_vsub    = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    assign valid_next = {valid_reg[sao_pkg::PIPE_LAT-2:0], accept};

    genvar i;
    for (i = 0; i < sao_pkg::NUM_LANES; i++)
    begin : g_lane
        sao_alpha_lane u_lane (
            .clk      (clk),
            .cfg      (cfg_reg),
            .oa       (over_alpha_quad[8*i +: 8]),
            .ma       (main_alpha_quad[8*i +: 8]),
            .lane_out (lanes[i])
        );
    end

    // Packed and alpha modes report the composited main alpha, the colour planes
    // pass the main alpha through.
    always_comb
    begin
        case (side_reg[MERGE_TAP].mode)
            sao_pkg::MODE_PACKED, sao_pkg::MODE_ALPHA: alpha_sel = lanes[0].mc;
            default:                                   alpha_sel = lanes[0].ma;
        endcase
    end

    always_comb
    begin
        side_next[0].mode  = sao_pkg::mode_t'(mode);
        side_next[0].rv    = right_valid;
        side_next[0].bv    = below_valid;
        side_next[0].o_r   = over_red_or_sample;
        side_next[0].o_g   = over_green;
        side_next[0].o_b   = over_blue;
        side_next[0].m_r   = main_red_or_sample;
        side_next[0].m_g   = main_green;
        side_next[0].m_b   = main_blue;
        side_next[0].alpha = '0;
        for (int k = 1; k < sao_pkg::PIPE_LAT; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[sao_pkg::LANE_LAT].alpha = alpha_sel;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < sao_pkg::PIPE_LAT; k++)
        begin
            side_reg[k] <= side_next[k];
        end
    end

    sao_merge u_merge (
        .clk         (clk),
        .cfg         (cfg_reg),
        .mode        (side_reg[MERGE_TAP].mode),
        .right_valid (side_reg[MERGE_TAP].rv),
        .below_valid (side_reg[MERGE_TAP].bv),
        .lanes       (lanes),
        .alpha       (merge_alpha)
    );

    assign mix_side = side_reg[MIX_TAP];

    sao_mix_lane u_mix_red (
        .clk      (clk),
        .en       (mix_side.mode != sao_pkg::MODE_ALPHA),
        .alpha    (merge_alpha),
        .main_val (mix_side.m_r),
        .over_val (mix_side.o_r),
        .blend    (out_red_or_sample)
    );

    sao_mix_lane u_mix_green (
        .clk      (clk),
        .en       (mix_side.mode == sao_pkg::MODE_PACKED),
        .alpha    (merge_alpha),
        .main_val (mix_side.m_g),
        .over_val (mix_side.o_g),
        .blend    (out_green)
    );

    sao_mix_lane u_mix_blue (
        .clk      (clk),
        .en       (mix_side.mode == sao_pkg::MODE_PACKED),
        .alpha    (merge_alpha),
        .main_val (mix_side.m_b),
        .over_val (mix_side.o_b),
        .blend    (out_blue)
    );

    assign done      = valid_reg[sao_pkg::PIPE_LAT-1];
    assign out_alpha = side_reg[sao_pkg::PIPE_LAT-1].alpha;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sao_pkg::PIPE_LAT) done)
        else $error("accepted item produced no result at the pipeline latency");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, sao_pkg::PIPE_LAT))
        else $error("result strobe without a matching accepted item");

    a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !cfg_reg.main_has_alpha) |->
            (out_alpha == $past(main_alpha_quad[7:0], sao_pkg::PIPE_LAT)))
        else $error("main alpha not passed through without main alpha");

    a_alpha_mode_red: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, sao_pkg::PIPE_LAT) == sao_pkg::MODE_ALPHA) |->
            (out_red_or_sample == $past(main_red_or_sample, sao_pkg::PIPE_LAT)))
        else $error("alpha mode changed the main sample");

    a_planar_green_blue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, sao_pkg::PIPE_LAT) != sao_pkg::MODE_PACKED) |->
            (out_green == $past(main_green, sao_pkg::PIPE_LAT)
             && out_blue == $past(main_blue, sao_pkg::PIPE_LAT)))
        else $error("planar mode changed main green or blue");
`endif

endmodule

/* tb/straight_alpha_overlay_blend_tb.sv */
// Self-checking testbench for straight_alpha_overlay_blend: a queue-fed driver sends
// directed and random pixels in bursts, and a monitor checks every result against a predictor.
// Depends on sao_pkg and the straight_alpha_overlay_blend RTL.
module straight_alpha_overlay_blend_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASE  = 61;

    typedef struct {
        sao_pkg::mode_t mode;
        logic [7:0]     o_r;
        logic [7:0]     o_g;
        logic [7:0]     o_b;
        logic [31:0]    oq;
        logic [7:0]     m_r;
        logic [7:0]     m_g;
        logic [7:0]     m_b;
        logic [31:0]    mq;
        logic           rv;
        logic           bv;
    } pixel_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } blend_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = sao_pkg::MODE_PACKED;
    logic [7:0]  over_red_or_sample = '0;
    logic [7:0]  over_green = '0;
    logic [7:0]  over_blue = '0;
    logic [31:0] over_alpha_quad = '0;
    logic [7:0]  main_red_or_sample = '0;
    logic [7:0]  main_green = '0;
    logic [7:0]  main_blue = '0;
    logic [31:0] main_alpha_quad = '0;
    logic        right_valid = 1'b0;
    logic        below_valid = 1'b0;
    logic        done;
    logic [7:0]  out_red_or_sample;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        cfg_write;
    logic [sao_pkg::CFG_IDX_W-1:0] cfg_index;
    logic        cfg_data;

    logic   cfg_alpha;
    logic   cfg_h;
    logic   cfg_v;
    pixel_t queued_pixels[$];
    blend_t expected_blends[$];
    pixel_t cur_pixel;
    int     burst_left = 0;
    int     gap_left = 0;
    int     errors = 0;
    int     cycles = 0;

    straight_alpha_overlay_blend dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .mode               (mode),
        .over_red_or_sample (over_red_or_sample),
        .over_green         (over_green),
        .over_blue          (over_blue),
        .over_alpha_quad    (over_alpha_quad),
        .main_red_or_sample (main_red_or_sample),
        .main_green         (main_green),
        .main_blue          (main_blue),
        .main_alpha_quad    (main_alpha_quad),
        .right_valid        (right_valid),
        .below_valid        (below_valid),
        .done               (done),
        .out_red_or_sample  (out_red_or_sample),
        .out_green          (out_green),
        .out_blue           (out_blue),
        .out_alpha          (out_alpha),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] div255_rnd(input logic [31:0] x);
        logic [31:0] t;
        t = ((x + 32'd128) * 32'd257) >> 16;
        return t[7:0];
    endfunction

    function automatic logic [7:0] straight_of(input logic [7:0] a, input logic [7:0] m);
        logic [31:0] a32;
        logic [31:0] m32;
        logic [31:0] den;
        logic [31:0] q;
        if (!cfg_alpha || a == sao_pkg::ALPHA_CLEAR || a == sao_pkg::ALPHA_OPAQUE)
            return a;
        a32 = a;
        m32 = m;
        den = 32'd255 * (a32 + m32) - a32 * m32;
        q = (32'd65025 * a32) / den;
        return q[7:0];
    endfunction

    function automatic logic [7:0] mix_of(input logic [7:0] m, input logic [7:0] o,
                                          input logic [7:0] a);
        logic [31:0] m32;
        logic [31:0] o32;
        logic [31:0] a32;
        if (a == sao_pkg::ALPHA_CLEAR)
            return m;
        if (a == sao_pkg::ALPHA_OPAQUE)
            return o;
        m32 = m;
        o32 = o;
        a32 = a;
        return div255_rnd(m32 * (32'd255 - a32) + o32 * a32);
    endfunction

    function automatic logic [7:0] composite_of(input logic [7:0] oa, input logic [7:0] ma);
        logic [7:0]  a;
        logic [31:0] ma32;
        logic [31:0] oa32;
        if (!cfg_alpha)
            return ma;
        a = straight_of(oa, ma);
        if (a == sao_pkg::ALPHA_CLEAR)
            return ma;
        if (a == sao_pkg::ALPHA_OPAQUE)
            return oa;
        ma32 = ma;
        oa32 = oa;
        return ma + div255_rnd((32'd255 - ma32) * oa32);
    endfunction

    function automatic logic [7:0] avg_of(input logic [31:0] q, input logic rv, input logic bv);
        logic [9:0] b0;
        logic [9:0] b1;
        logic [9:0] b2;
        logic [9:0] b3;
        logic [9:0] h;
        logic [9:0] v;
        logic [9:0] s;
        b0 = {2'b00, q[7:0]};
        b1 = {2'b00, q[15:8]};
        b2 = {2'b00, q[23:16]};
        b3 = {2'b00, q[31:24]};
        if (cfg_h && cfg_v && rv && bv)
        begin
            s = b0 + b1 + b2 + b3;
            return s[9:2];
        end
        if (cfg_h || cfg_v)
        begin
            h = (cfg_h && rv) ? (b0 + b1) >> 1 : b0;
            v = (cfg_v && bv) ? (b0 + b2) >> 1 : b0;
            s = h + v;
            return s[8:1];
        end
        return b0[7:0];
    endfunction

    function automatic blend_t blend_pixel(input pixel_t p);
        blend_t      res;
        logic [7:0]  a;
        logic [7:0]  ad;
        logic [31:0] mc;
        res.r = p.m_r;
        res.g = p.m_g;
        res.b = p.m_b;
        res.a = p.mq[7:0];
        case (p.mode)
            sao_pkg::MODE_PACKED:
            begin
                a = straight_of(p.oq[7:0], p.mq[7:0]);
                res.r = mix_of(p.m_r, p.o_r, a);
                res.g = mix_of(p.m_g, p.o_g, a);
                res.b = mix_of(p.m_b, p.o_b, a);
                res.a = composite_of(p.oq[7:0], p.mq[7:0]);
            end
            sao_pkg::MODE_ALPHA:
            begin
                res.a = composite_of(p.oq[7:0], p.mq[7:0]);
            end
            sao_pkg::MODE_LUMA:
            begin
                a = straight_of(p.oq[7:0], composite_of(p.oq[7:0], p.mq[7:0]));
                res.r = mix_of(p.m_r, p.o_r, a);
            end
            default:
            begin
                for (int i = 0; i < sao_pkg::NUM_LANES; i++)
                    mc[8*i +: 8] = composite_of(p.oq[8*i +: 8], p.mq[8*i +: 8]);
                a = avg_of(p.oq, p.rv, p.bv);
                ad = avg_of(mc, p.rv, p.bv);
                a = straight_of(a, ad);
                res.r = mix_of(p.m_r, p.o_r, a);
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(0, 5))
            0: return sao_pkg::ALPHA_CLEAR;
            1: return sao_pkg::ALPHA_OPAQUE;
            2: return 8'($urandom_range(1, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.mode = sao_pkg::mode_t'($urandom_range(0, 3));
        p.o_r  = 8'($urandom);
        p.o_g  = 8'($urandom);
        p.o_b  = 8'($urandom);
        p.m_r  = 8'($urandom);
        p.m_g  = 8'($urandom);
        p.m_b  = 8'($urandom);
        for (int i = 0; i < sao_pkg::NUM_LANES; i++)
        begin
            p.oq[8*i +: 8] = rand_alpha();
            p.mq[8*i +: 8] = rand_alpha();
        end
        p.rv = 1'($urandom_range(0, 1));
        p.bv = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic push_pixel(input sao_pkg::mode_t md, input logic [7:0] o,
                              input logic [31:0] oq,
                              input logic [7:0] m, input logic [31:0] mq,
                              input logic rv, input logic bv);
        pixel_t p;
        p.mode = md;
        p.o_r  = o;
        p.o_g  = ~o;
        p.o_b  = o ^ 8'h5a;
        p.oq   = oq;
        p.m_r  = m;
        p.m_g  = ~m;
        p.m_b  = m ^ 8'h3c;
        p.mq   = mq;
        p.rv   = rv;
        p.bv   = bv;
        queued_pixels.push_back(p);
    endtask

    // Fully transparent and fully opaque alpha, the un-premultiply that saturates to
    // opaque, every mode, and chroma averaging with both, only the right or only the below neighbour valid.
    task automatic add_directed();
        push_pixel(sao_pkg::MODE_PACKED, 8'h00, 32'h0000_0000, 8'h00, 32'h0000_0000, 1'b0, 1'b0);
        push_pixel(sao_pkg::MODE_PACKED, 8'hff, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1'b1, 1'b1);
        push_pixel(sao_pkg::MODE_PACKED, 8'h9c, 32'h1122_3300, 8'h31, 32'h4455_66a0, 1'b0, 1'b1);
        push_pixel(sao_pkg::MODE_PACKED, 8'h27, 32'h00ee_00ff, 8'hd4, 32'h0000_0040, 1'b1, 1'b0);
        push_pixel(sao_pkg::MODE_PACKED, 8'hc3, 32'h0000_0080, 8'h18, 32'h0000_0000, 1'b0, 1'b0);
        push_pixel(sao_pkg::MODE_PACKED, 8'h6e, 32'h0000_0037, 8'hb2, 32'h0000_00c8, 1'b0, 1'b0);
        push_pixel(sao_pkg::MODE_ALPHA,  8'h55, 32'h0000_0090, 8'ha5, 32'h0000_0030, 1'b0, 1'b0);
        push_pixel(sao_pkg::MODE_ALPHA,  8'hf0, 32'h0000_0000, 8'h0f, 32'h0000_00ab, 1'b1, 1'b1);
        push_pixel(sao_pkg::MODE_LUMA,   8'he1, 32'h0000_0060, 8'h12, 32'h0000_0020, 1'b0, 1'b0);
        push_pixel(sao_pkg::MODE_LUMA,   8'h80, 32'h0000_00ff, 8'h7f, 32'h0000_0000, 1'b1, 1'b0);
        push_pixel(sao_pkg::MODE_CHROMA, 8'hd0, 32'h1080_f040, 8'h20, 32'h3070_c0e0, 1'b1, 1'b1);
        push_pixel(sao_pkg::MODE_CHROMA, 8'h40, 32'h1080_f040, 8'hc0, 32'hff00_5a01, 1'b1, 1'b0);
        push_pixel(sao_pkg::MODE_CHROMA, 8'h99, 32'h2004_e8fe, 8'h66, 32'h00ff_1080, 1'b0, 1'b1);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            queued_pixels.push_back(rand_pixel());
    endtask

    task automatic write_reg(input sao_pkg::reg_idx_t idx, input logic val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sao_pkg::REG_MAIN_HAS_ALPHA: cfg_alpha = val;
            sao_pkg::REG_CHROMA_HSUB:    cfg_h = val;
            default:                     cfg_v = val;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        do
            @(posedge clk);
        while (queued_pixels.size() != 0 || start || expected_blends.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_blends.push_back(blend_pixel(cur_pixel));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (queued_pixels.size() > 0)
                begin
                    cur_pixel = queued_pixels.pop_front();
                    start              <= 1'b1;
                    mode               <= cur_pixel.mode;
                    over_red_or_sample <= cur_pixel.o_r;
                    over_green         <= cur_pixel.o_g;
                    over_blue          <= cur_pixel.o_b;
                    over_alpha_quad    <= cur_pixel.oq;
                    main_red_or_sample <= cur_pixel.m_r;
                    main_green         <= cur_pixel.m_g;
                    main_blue          <= cur_pixel.m_b;
                    main_alpha_quad    <= cur_pixel.mq;
                    right_valid        <= cur_pixel.rv;
                    below_valid        <= cur_pixel.bv;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        blend_t want;
        if (rst_n && done)
        begin
            if (expected_blends.size() == 0)
            begin
                report_mismatch("result with no transfer outstanding");
            end
            else
            begin
                want = expected_blends.pop_front();
                if (out_red_or_sample !== want.r)
                    report_mismatch($sformatf("out_red_or_sample got %0h want %0h",
                                              out_red_or_sample, want.r));
                if (out_green !== want.g)
                    report_mismatch($sformatf("out_green got %0h want %0h", out_green, want.g));
                if (out_blue !== want.b)
                    report_mismatch($sformatf("out_blue got %0h want %0h", out_blue, want.b));
                if (out_alpha !== want.a)
                    report_mismatch($sformatf("out_alpha got %0h want %0h", out_alpha, want.a));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("straight_alpha_overlay_blend regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] combo;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = sao_pkg::REG_MAIN_HAS_ALPHA;
        cfg_data           = 1'b0;
        cfg_alpha          = 1'b0;
        cfg_h              = 1'b0;
        cfg_v              = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        add_random(RANDOM_PHASE);
        wait_idle(4);

        for (int c = 0; c < 8; c++)
        begin
            combo = 3'(c);
            write_reg(sao_pkg::REG_MAIN_HAS_ALPHA, combo[0]);
            write_reg(sao_pkg::REG_CHROMA_HSUB, combo[1]);
            write_reg(sao_pkg::REG_CHROMA_VSUB, combo[2]);
            if (combo == 3'b111)
                add_directed();
            add_random(RANDOM_PHASE);
            wait_idle(4);
        end

        wait_idle(sao_pkg::PIPE_LAT + 4);
        if (errors == 0 && expected_blends.size() == 0)
            $display("straight_alpha_overlay_blend regression: pass");
        else
            $display("straight_alpha_overlay_blend regression: fail");
        $finish;
    end

endmodule
